### src/esgs_pkg.sv
// ----------------------------------------------------------------------------
// esgs_pkg
// Shared types, constants and the x*log2(x) table for the split gain search.
// ----------------------------------------------------------------------------
package esgs_pkg;

  // sample store sizing
  localparam int SAMPLE_MAX = 8;
  localparam int CNT_W      = 4;
  localparam int IDX_W      = 3;

  // field widths
  localparam int VAL_W  = 16;
  localparam int S_W    = 20;
  localparam int XLOG_W = 21;
  localparam int GAIN_W = 19;
  localparam int BASE_W = 18;

  localparam logic [BASE_W-1:0] BASE_RESET = 18'd21101;

  // divider: quotient bits retired per cycle
  localparam int DIV_STEP = 4;
  localparam int DIV_CYC  = S_W / DIV_STEP;
  localparam int DCNT_W   = 3;

  // configuration register indexes (word address bit)
  localparam logic REG_BASELINE = 1'b0;

  typedef enum logic [2:0] {
    F_LOAD,
    F_RDTHR,
    F_SCAN,
    F_SUM,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_STORE,
    B_EMIT
  } back_state_t;

  // one candidate word passed from front to back
  typedef struct packed {
    logic [VAL_W-1:0] thr;
    logic [S_W-1:0]   s;
    logic [CNT_W-1:0] n;
    logic             last;
  } cand_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // round(x * log2(x) * 2^16), zero for x below two or above eight
  function automatic logic [XLOG_W-1:0] xlog(input logic [CNT_W-1:0] x);
    logic [XLOG_W-1:0] r;
    case (x)
      4'd2:    r = 21'd131072;
      4'd3:    r = 21'd311616;
      4'd4:    r = 21'd524288;
      4'd5:    r = 21'd760849;
      4'd6:    r = 21'd1016449;
      4'd7:    r = 21'd1287880;
      4'd8:    r = 21'd1572864;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### src/entropy_split_gain_search.sv
// ----------------------------------------------------------------------------
// entropy_split_gain_search
// Information gain split search over a set of labelled samples.
// ----------------------------------------------------------------------------
// Samples enter one word at a time: a word is taken at an edge with start
// high and busy low. Words are stored until one marked in_last_sample; up to
// eight are kept and later words of the same set are dropped. The marked
// word starts the search and busy stays high while the scanner runs.
// For every stored sample, in storage order, one result word appears on the
// out_ ports for a single cycle with out_valid high; the receiver must take
// it then, it cannot stall the block. out_is_best flags every maximum gain
// and out_last_result flags the final word of the set.
// For a set of n samples the scanner makes one pass over the sample memory
// per candidate, one read per cycle; busy falls once every candidate is
// pushed. The divider sits behind a two-entry queue; the n results are
// then played out in one unbroken burst. Loading of the next set may
// overlap that playback. The user must write the gain register through
// the APB port only while idle; the block itself does not enforce this.
// Reset clears all control state and loads the default baseline gain.
// ----------------------------------------------------------------------------
module entropy_split_gain_search (
  input  logic        clk,
  input  logic        rst_n,
  // sample channel
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_feature_value,
  input  logic        in_class_label,
  input  logic        in_last_sample,
  // result channel
  output logic        out_valid,
  output logic [15:0] out_threshold,
  output logic signed [18:0] out_gain,
  output logic        out_is_best,
  output logic        out_last_result,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                          front_ready, in_acc;
  logic                          q_push, q_pop;
  esgs_pkg::cand_t               push_word, pop_word;
  esgs_pkg::qstat_t              q_stat;
  logic [esgs_pkg::BASE_W-1:0]   baseline_r, baseline_nxt;
  logic                          cfg_wr;

  assign busy   = !front_ready;
  assign in_acc = start && front_ready;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == esgs_pkg::REG_BASELINE);
  assign baseline_nxt = cfg_wr ? pwdata[esgs_pkg::BASE_W-1:0] : baseline_r;
  assign prdata = (paddr[2] == esgs_pkg::REG_BASELINE) ?
                  {{(32-esgs_pkg::BASE_W){1'b0}}, baseline_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      baseline_r <= esgs_pkg::BASE_RESET;
    end else begin
      baseline_r <= baseline_nxt;
    end
  end

  // store and scanner
  esgs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_acc        (in_acc),
    .feature_value (in_feature_value),
    .class_label   (in_class_label),
    .last_sample   (in_last_sample),
    .ready         (front_ready),
    .q_stat        (q_stat),
    .push          (q_push),
    .cand          (push_word)
  );

  // candidate queue
  esgs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (push_word),
    .pop       (q_pop),
    .pop_word  (pop_word),
    .stat      (q_stat)
  );

  // divider and result playback
  esgs_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .pop             (q_pop),
    .cand            (pop_word),
    .baseline        (baseline_r),
    .out_valid       (out_valid),
    .out_threshold   (out_threshold),
    .out_gain        (out_gain),
    .out_is_best     (out_is_best),
    .out_last_result (out_last_result)
  );

endmodule

### src/esgs_queue.sv
// ----------------------------------------------------------------------------
// esgs_queue
// Two-entry queue of candidate words between the scanner and the divider.
// ----------------------------------------------------------------------------
module esgs_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  esgs_pkg::cand_t push_word,
  input  logic            pop,
  output esgs_pkg::cand_t pop_word,
  output esgs_pkg::qstat_t stat
);

  esgs_pkg::cand_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  // handshake qualification
  assign do_push = push && (cnt_r != 2'd2);
  assign do_pop  = pop && (cnt_r != 2'd0);

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign pop_word   = slot_r[rd_ptr_r];

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

### src/esgs_front.sv
// ----------------------------------------------------------------------------
// esgs_front
// Sample store and candidate scanner: counts each side of every threshold
// and forms the summed x*log2(x) entropy term.
// ----------------------------------------------------------------------------
module esgs_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_acc,
  input  logic [esgs_pkg::VAL_W-1:0]    feature_value,
  input  logic                          class_label,
  input  logic                          last_sample,
  output logic                          ready,
  input  esgs_pkg::qstat_t              q_stat,
  output logic                          push,
  output esgs_pkg::cand_t               cand
);

  esgs_pkg::front_state_t state_r, state_nxt;

  // sample memory: value and label per word
  logic [esgs_pkg::VAL_W:0]   sample_mem [esgs_pkg::SAMPLE_MAX];
  logic [esgs_pkg::VAL_W:0]   rd_data_r;
  logic [esgs_pkg::IDX_W-1:0] rd_addr;
  logic                       we;

  logic [esgs_pkg::CNT_W-1:0] count_r, pos_r;
  logic [esgs_pkg::CNT_W-1:0] count_new, pos_new;
  logic [esgs_pkg::CNT_W-1:0] n_r, kt_r;
  logic [esgs_pkg::IDX_W-1:0] i_r;
  logic [esgs_pkg::CNT_W-1:0] j_r;
  logic [esgs_pkg::CNT_W-1:0] nu_r, ku_r;
  logic [esgs_pkg::VAL_W-1:0] thr_r;
  logic [esgs_pkg::S_W-1:0]   s_r;

  logic [esgs_pkg::CNT_W-1:0]  nl, kl;
  logic [esgs_pkg::XLOG_W-1:0] side_u, side_l, s_sum;
  logic                        cand_last, scan_done, upper_hit;

  // load bookkeeping
  assign we        = in_acc && (count_r < esgs_pkg::CNT_W'(esgs_pkg::SAMPLE_MAX));
  assign count_new = we ? count_r + 1'b1 : count_r;
  assign pos_new   = (we && class_label) ? pos_r + 1'b1 : pos_r;

  // scan status
  assign cand_last = (({1'b0, i_r} + 1'b1) == n_r);
  assign scan_done = (j_r == n_r);
  assign upper_hit = (rd_data_r[esgs_pkg::VAL_W:1] >= thr_r);

  // entropy term of both sides
  always_comb begin
    nl     = n_r - nu_r;
    kl     = kt_r - ku_r;
    side_u = esgs_pkg::xlog(nu_r) - esgs_pkg::xlog(ku_r) - esgs_pkg::xlog(nu_r - ku_r);
    side_l = esgs_pkg::xlog(nl) - esgs_pkg::xlog(kl) - esgs_pkg::xlog(nl - kl);
    s_sum  = side_u + side_l;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      esgs_pkg::F_LOAD: begin
        if (in_acc && last_sample) state_nxt = esgs_pkg::F_RDTHR;
      end
      esgs_pkg::F_RDTHR: state_nxt = esgs_pkg::F_SCAN;
      esgs_pkg::F_SCAN: begin
        if (scan_done) state_nxt = esgs_pkg::F_SUM;
      end
      esgs_pkg::F_SUM: state_nxt = esgs_pkg::F_PUSH;
      esgs_pkg::F_PUSH: begin
        if (!q_stat.full) state_nxt = cand_last ? esgs_pkg::F_LOAD : esgs_pkg::F_RDTHR;
      end
      default: state_nxt = esgs_pkg::F_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    ready     = 1'b0;
    push      = 1'b0;
    rd_addr   = j_r[esgs_pkg::IDX_W-1:0];
    case (state_r)
      esgs_pkg::F_LOAD:  ready = 1'b1;
      esgs_pkg::F_RDTHR: rd_addr = i_r;
      esgs_pkg::F_PUSH:  push = 1'b1;
      default: ;
    endcase
    cand.thr  = thr_r;
    cand.s    = s_r;
    cand.n    = n_r;
    cand.last = cand_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= esgs_pkg::F_LOAD;
      count_r <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == esgs_pkg::F_LOAD && in_acc) begin
        count_r <= last_sample ? '0 : count_new;
        pos_r   <= last_sample ? '0 : pos_new;
      end
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    case (state_r)
      esgs_pkg::F_LOAD: begin
        n_r  <= count_new;
        kt_r <= pos_new;
        i_r  <= '0;
      end
      esgs_pkg::F_RDTHR: j_r <= '0;
      esgs_pkg::F_SCAN: begin
        j_r <= j_r + 1'b1;
        if (j_r == '0) begin
          thr_r <= rd_data_r[esgs_pkg::VAL_W:1];
          nu_r  <= '0;
          ku_r  <= '0;
        end else if (upper_hit) begin
          nu_r <= nu_r + 1'b1;
          ku_r <= ku_r + {{(esgs_pkg::CNT_W-1){1'b0}}, rd_data_r[0]};
        end
      end
      esgs_pkg::F_SUM: s_r <= s_sum[esgs_pkg::S_W-1:0];
      esgs_pkg::F_PUSH: begin
        if (!q_stat.full) i_r <= i_r + 1'b1;
      end
      default: ;
    endcase
  end

  // sample memory ports
  always_ff @(posedge clk) begin
    if (we) begin
      sample_mem[count_r[esgs_pkg::IDX_W-1:0]] <= {feature_value, class_label};
    end
    rd_data_r <= sample_mem[rd_addr];
  end

endmodule

### src/esgs_back.sv
// ----------------------------------------------------------------------------
// esgs_back
// Divides each entropy term by the sample count, forms the gain, tracks the
// maximum and plays the results out once the set is complete.
// ----------------------------------------------------------------------------
module esgs_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  esgs_pkg::qstat_t              q_stat,
  output logic                          pop,
  input  esgs_pkg::cand_t               cand,
  input  logic [esgs_pkg::BASE_W-1:0]   baseline,
  output logic                          out_valid,
  output logic [esgs_pkg::VAL_W-1:0]    out_threshold,
  output logic signed [esgs_pkg::GAIN_W-1:0] out_gain,
  output logic                          out_is_best,
  output logic                          out_last_result
);

  esgs_pkg::back_state_t state_r, state_nxt;

  logic [esgs_pkg::VAL_W-1:0]  thr_r;
  logic [esgs_pkg::CNT_W-1:0]  n_r;
  logic                        last_r;
  logic [esgs_pkg::CNT_W-1:0]  rem_r, rem_nxt;
  logic [esgs_pkg::S_W-1:0]    quo_r, quo_nxt;
  logic [esgs_pkg::DCNT_W-1:0] dcnt_r;
  logic [esgs_pkg::IDX_W-1:0]  wr_idx_r, emit_idx_r;
  logic signed [esgs_pkg::GAIN_W-1:0] best_r;

  // result buffers, written in candidate order
  logic [esgs_pkg::VAL_W-1:0]         thr_buf_r  [esgs_pkg::SAMPLE_MAX];
  logic signed [esgs_pkg::GAIN_W-1:0] gain_buf_r [esgs_pkg::SAMPLE_MAX];

  logic [esgs_pkg::S_W:0]             diff;
  logic signed [esgs_pkg::GAIN_W-1:0] gain;
  logic                               div_done, emit_last;

  // four restoring division steps per cycle; remainder stays below n
  always_comb begin
    logic [esgs_pkg::CNT_W-1:0] r;
    r       = rem_r;
    quo_nxt = quo_r;
    for (int b = 0; b < esgs_pkg::DIV_STEP; b++) begin
      r       = {r[esgs_pkg::CNT_W-2:0], quo_nxt[esgs_pkg::S_W-1]};
      quo_nxt = {quo_nxt[esgs_pkg::S_W-2:0], 1'b0};
      if (r >= n_r) begin
        r          = r - n_r;
        quo_nxt[0] = 1'b1;
      end
    end
    rem_nxt = r;
  end

  // gain = baseline - quotient
  assign diff      = {{(esgs_pkg::S_W+1-esgs_pkg::BASE_W){1'b0}}, baseline} - {1'b0, quo_r};
  assign gain      = diff[esgs_pkg::GAIN_W-1:0];
  assign div_done  = (dcnt_r == esgs_pkg::DCNT_W'(esgs_pkg::DIV_CYC - 1));
  assign emit_last = (({1'b0, emit_idx_r} + 1'b1) == n_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      esgs_pkg::B_IDLE: begin
        if (!q_stat.empty) state_nxt = esgs_pkg::B_DIV;
      end
      esgs_pkg::B_DIV: begin
        if (div_done) state_nxt = esgs_pkg::B_STORE;
      end
      esgs_pkg::B_STORE: state_nxt = last_r ? esgs_pkg::B_EMIT : esgs_pkg::B_IDLE;
      esgs_pkg::B_EMIT: begin
        if (emit_last) state_nxt = esgs_pkg::B_IDLE;
      end
      default: state_nxt = esgs_pkg::B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop       = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      esgs_pkg::B_IDLE: pop = !q_stat.empty;
      esgs_pkg::B_EMIT: out_valid = 1'b1;
      default: ;
    endcase
    out_threshold   = thr_buf_r[emit_idx_r];
    out_gain        = gain_buf_r[emit_idx_r];
    out_is_best     = (gain_buf_r[emit_idx_r] == best_r);
    out_last_result = emit_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= esgs_pkg::B_IDLE;
      wr_idx_r   <= '0;
      emit_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == esgs_pkg::B_STORE) begin
        wr_idx_r <= last_r ? '0 : wr_idx_r + 1'b1;
      end
      if (state_r == esgs_pkg::B_EMIT) begin
        emit_idx_r <= emit_last ? '0 : emit_idx_r + 1'b1;
      end
    end
  end

  // divider and buffer datapath
  always_ff @(posedge clk) begin
    case (state_r)
      esgs_pkg::B_IDLE: begin
        thr_r  <= cand.thr;
        n_r    <= cand.n;
        last_r <= cand.last;
        quo_r  <= cand.s;
        rem_r  <= '0;
        dcnt_r <= '0;
      end
      esgs_pkg::B_DIV: begin
        quo_r  <= quo_nxt;
        rem_r  <= rem_nxt;
        dcnt_r <= dcnt_r + 1'b1;
      end
      esgs_pkg::B_STORE: begin
        thr_buf_r[wr_idx_r]  <= thr_r;
        gain_buf_r[wr_idx_r] <= gain;
        if (wr_idx_r == '0 || gain > best_r) best_r <= gain;
      end
      default: ;
    endcase
  end

endmodule

### tb/entropy_split_gain_search_checker.sv
// ----------------------------------------------------------------------------
// entropy_split_gain_search_checker
// Watches the sample, result and configuration channels of the split gain
// search, forecasts every result word from the accepted sample words and
// compares each result word field by field as it leaves the block.
// ----------------------------------------------------------------------------
module entropy_split_gain_search_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  // sample channel
  input  logic                        start,
  input  logic                        busy,
  input  logic [esgs_pkg::VAL_W-1:0]  in_feature_value,
  input  logic                        in_class_label,
  input  logic                        in_last_sample,
  // result channel
  input  logic                        out_valid,
  input  logic [esgs_pkg::VAL_W-1:0]  out_threshold,
  input  logic [esgs_pkg::GAIN_W-1:0] out_gain,
  input  logic                        out_is_best,
  input  logic                        out_last_result,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  input  logic [31:0]                 prdata,
  input  logic                        pready,
  // status towards the test top
  output int                          mismatch_count,
  output int                          splits_owed
);

  localparam logic [2:0] ADDR_BASELINE = {esgs_pkg::REG_BASELINE, 2'b00};

  typedef struct {
    logic [esgs_pkg::VAL_W-1:0]  thr;
    logic [esgs_pkg::GAIN_W-1:0] gain;
    logic                        best;
    logic                        last;
  } split_word_t;

  // own copy of the block state
  logic [esgs_pkg::VAL_W-1:0]  value_mem [esgs_pkg::SAMPLE_MAX];
  logic                        label_mem [esgs_pkg::SAMPLE_MAX];
  int                          held;
  logic [esgs_pkg::BASE_W-1:0] baseline;
  split_word_t                 owed_splits [$];
  int                          errs = 0;

  // round(x * log2(x) * 2^16), zero below two
  function automatic longint xlog_q16(input int x);
    real r;
    if (x < 2) return 0;
    r = real'(x) * ($ln(real'(x)) / $ln(2.0)) * 65536.0;
    return longint'($rtoi(r + 0.5));
  endfunction

  // entropy sum of one side holding n words, k of them positive
  function automatic longint side_entropy(input int n, input int k);
    return xlog_q16(n) - xlog_q16(k) - xlog_q16(n - k);
  endfunction

  // one split word per held sample, every maximum gain flagged
  function automatic void score_candidates();
    longint gains [esgs_pkg::SAMPLE_MAX];
    longint top_gain;
    longint s;
    int nu, ku, nl, kl;
    split_word_t w;
    top_gain = 0;
    for (int i = 0; i < held; i++) begin
      nu = 0; ku = 0; nl = 0; kl = 0;
      for (int j = 0; j < held; j++) begin
        if (value_mem[j] >= value_mem[i]) begin
          nu++;
          ku += int'(label_mem[j]);
        end else begin
          nl++;
          kl += int'(label_mem[j]);
        end
      end
      s = side_entropy(nu, ku) + side_entropy(nl, kl);
      gains[i] = longint'(baseline) - s / held;
      if (i == 0 || gains[i] > top_gain) top_gain = gains[i];
    end
    for (int i = 0; i < held; i++) begin
      w.thr  = value_mem[i];
      w.gain = gains[i][esgs_pkg::GAIN_W-1:0];
      w.best = (gains[i] == top_gain);
      w.last = (i == held - 1);
      owed_splits.push_back(w);
    end
  endfunction

  always @(posedge clk) begin
    split_word_t want;
    if (!rst_n) begin
      held     = 0;
      baseline = esgs_pkg::BASE_RESET;
      owed_splits.delete();
    end else begin
      // result word against the oldest forecast
      if (out_valid) begin
        if (owed_splits.size() == 0) begin
          errs++;
          $display("%0t: unexpected result word thr=%h gain=%0d best=%b last=%b",
                   $time, out_threshold, $signed(out_gain), out_is_best, out_last_result);
        end else begin
          want = owed_splits.pop_front();
          if (out_threshold !== want.thr || out_gain !== want.gain ||
              out_is_best !== want.best || out_last_result !== want.last) begin
            errs++;
            $display("%0t: result mismatch expected thr=%h gain=%0d best=%b last=%b",
                     $time, want.thr, $signed(want.gain), want.best, want.last);
            $display("%0t:                   actual thr=%h gain=%0d best=%b last=%b",
                     $time, out_threshold, $signed(out_gain), out_is_best,
                     out_last_result);
          end
        end
      end
      // register traffic
      if (psel && penable && pready && paddr == ADDR_BASELINE) begin
        if (pwrite) begin
          baseline = pwdata[esgs_pkg::BASE_W-1:0];
        end else if (prdata !== 32'(baseline)) begin
          errs++;
          $display("%0t: baseline read mismatch expected %h actual %h",
                   $time, 32'(baseline), prdata);
        end
      end
      // accepted sample word
      if (start && !busy) begin
        if (held < esgs_pkg::SAMPLE_MAX) begin
          value_mem[held] = in_feature_value;
          label_mem[held] = in_class_label;
          held++;
        end
        if (in_last_sample) begin
          score_candidates();
          held = 0;
        end
      end
    end
    mismatch_count <= errs;
    splits_owed    <= owed_splits.size();
  end

endmodule

### tb/entropy_split_gain_search_test.sv
// ----------------------------------------------------------------------------
// entropy_split_gain_search_test
// Drives sample sets into the split gain search and gives the verdict. A
// directed part covers single-sample sets, extreme values, a full store with
// dropped words, tied values and baseline extremes; random sets follow, with
// random gaps and baseline changes. The checker does all result comparison.
// ----------------------------------------------------------------------------
module entropy_split_gain_search_test;

  localparam int         CYCLE_LIMIT   = 200000;
  localparam int         SETTLE_CYCLES = 40;
  localparam int         WORD_TARGET   = 150;
  localparam logic [2:0] ADDR_BASELINE = {esgs_pkg::REG_BASELINE, 2'b00};

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [esgs_pkg::VAL_W-1:0]  in_feature_value = '0;
  logic                        in_class_label = 1'b0;
  logic                        in_last_sample = 1'b0;
  logic                        out_valid;
  logic [esgs_pkg::VAL_W-1:0]  out_threshold;
  logic [esgs_pkg::GAIN_W-1:0] out_gain;
  logic                        out_is_best;
  logic                        out_last_result;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [2:0]                  paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;
  int                          mismatch_count;
  int                          splits_owed;
  int                          cycles = 0;
  int                          words_sent = 0;

  entropy_split_gain_search u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_feature_value(in_feature_value),
    .in_class_label  (in_class_label),
    .in_last_sample  (in_last_sample),
    .out_valid       (out_valid),
    .out_threshold   (out_threshold),
    .out_gain        (out_gain),
    .out_is_best     (out_is_best),
    .out_last_result (out_last_result),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  entropy_split_gain_search_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_feature_value(in_feature_value),
    .in_class_label  (in_class_label),
    .in_last_sample  (in_last_sample),
    .out_valid       (out_valid),
    .out_threshold   (out_threshold),
    .out_gain        (out_gain),
    .out_is_best     (out_is_best),
    .out_last_result (out_last_result),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .mismatch_count  (mismatch_count),
    .splits_owed     (splits_owed)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // present one sample word and hold it until taken
  task automatic send_word(input logic [esgs_pkg::VAL_W-1:0] v, input logic l,
                           input logic last);
    start            <= 1'b1;
    in_feature_value <= v;
    in_class_label   <= l;
    in_last_sample   <= last;
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  // sender gap, start dropped for its length
  task automatic pause(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // wait for every forecast word and a quiet block
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (splits_owed != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_BASELINE;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // write the baseline and read it straight back
  task automatic set_baseline(input logic [esgs_pkg::BASE_W-1:0] v);
    wait_idle();
    cfg_access(1'b1, 32'(v));
    cfg_access(1'b0, '0);
  endtask

  function automatic logic [esgs_pkg::BASE_W-1:0] pick_baseline();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return esgs_pkg::BASE_W'(131072);
      2:       return esgs_pkg::BASE_RESET;
      default: return esgs_pkg::BASE_W'($urandom_range(0, 131072));
    endcase
  endfunction

  // one set of random size and content, sometimes overfilling the store
  task automatic random_set();
    int size, vmode, lmode;
    logic tight;
    logic [esgs_pkg::VAL_W-1:0] v;
    logic l;
    size  = ($urandom_range(0, 99) < 85) ?
            $urandom_range(1, esgs_pkg::SAMPLE_MAX) :
            $urandom_range(esgs_pkg::SAMPLE_MAX + 1, esgs_pkg::SAMPLE_MAX + 3);
    vmode = $urandom_range(0, 2);
    lmode = $urandom_range(0, 4);
    tight = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < size; k++) begin
      case (vmode)
        0:       v = esgs_pkg::VAL_W'($urandom);
        1:       v = esgs_pkg::VAL_W'($urandom_range(0, 7));
        default: v = ($urandom_range(0, 1) == 0) ? '0 :
                     ($urandom_range(0, 1) == 0) ? '1 : esgs_pkg::VAL_W'($urandom);
      endcase
      l = (lmode == 0) ? 1'b0 : (lmode == 1) ? 1'b1 : 1'($urandom_range(0, 1));
      send_word(v, l, k == size - 1);
      if (!tight) pause(pick_gap());
    end
  endtask

  initial begin
    int r;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single sample, lower side empty
    send_word(16'h0000, 1'b0, 1'b1);
    pause(3);
    // value extremes
    send_word(16'hFFFF, 1'b1, 1'b0);
    send_word(16'h0000, 1'b0, 1'b1);
    // full store, then dropped words, the last one closing the set
    send_word(16'd5, 1'b1, 1'b0);
    send_word(16'd3, 1'b0, 1'b0);
    send_word(16'd5, 1'b0, 1'b0);
    send_word(16'd9, 1'b1, 1'b0);
    pause(12);
    send_word(16'd1, 1'b0, 1'b0);
    send_word(16'd9, 1'b1, 1'b0);
    send_word(16'd0, 1'b0, 1'b0);
    send_word(16'd7, 1'b1, 1'b0);
    send_word(16'h1234, 1'b1, 1'b0);
    send_word(16'hFFFF, 1'b0, 1'b1);
    pause(1);
    // all values tied, all positive
    send_word(16'hA5A5, 1'b1, 1'b0);
    send_word(16'hA5A5, 1'b1, 1'b0);
    send_word(16'hA5A5, 1'b1, 1'b1);

    // baseline extremes
    set_baseline(esgs_pkg::BASE_W'(131072));
    send_word(16'h5A5A, 1'b0, 1'b0);
    send_word(16'h0001, 1'b1, 1'b0);
    send_word(16'h8000, 1'b1, 1'b0);
    send_word(16'h0001, 1'b0, 1'b1);
    set_baseline('0);
    send_word(16'h7FFF, 1'b1, 1'b0);
    send_word(16'h0002, 1'b0, 1'b0);
    send_word(16'h7FFF, 1'b0, 1'b1);
    set_baseline(esgs_pkg::BASE_RESET);

    // random sets
    while (words_sent < WORD_TARGET) begin
      random_set();
      r = $urandom_range(0, 9);
      if (r < 2) set_baseline(pick_baseline());
      else if (r == 2) wait_idle();
      else pause(pick_gap());
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
